// ===== design/bdjn_pkg.sv =====
// Package for the button debounce and joystick normaliser.
// Holds field widths, register indexes, reset values and the command and status types.
// No dependencies.
package bdjn_pkg;

    localparam int TIME_W     = 32;
    localparam int LEVELS_W   = 8;
    localparam int SAMPLE_W   = 12;
    localparam int AXIS_W     = 16;
    localparam int DEBOUNCE_W = 24;
    localparam int DEADZONE_W = 15;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam int Q_FRAC     = 14;
    localparam int Q_ONE      = 16384;
    localparam int MAG_W      = 15;

    localparam int DIV_W      = 28;
    localparam int DIV_PER_CYC = 4;
    localparam int DIV_CYCLES = DIV_W / DIV_PER_CYC;
    localparam int CNT_W      = $clog2(DIV_CYCLES);

    localparam logic [DEBOUNCE_W-1:0] RST_DEBOUNCE = 24'd20000;
    localparam logic [DEADZONE_W-1:0] RST_DEADZONE = 15'd1638;
    localparam logic [SAMPLE_W-1:0]   RST_CENTER   = 12'd2048;
    localparam logic [SAMPLE_W-1:0]   RST_MIN      = 12'd0;
    localparam logic [SAMPLE_W-1:0]   RST_MAX      = 12'd4095;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_DEBOUNCE = 3'd0,
        REG_DEADZONE = 3'd1,
        REG_X_CENTER = 3'd2,
        REG_X_MIN    = 3'd3,
        REG_X_MAX    = 3'd4,
        REG_Y_CENTER = 3'd5,
        REG_Y_MIN    = 3'd6,
        REG_Y_MAX    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_time;
        logic [DEADZONE_W-1:0] deadzone;
        logic [SAMPLE_W-1:0]   x_center;
        logic [SAMPLE_W-1:0]   x_min;
        logic [SAMPLE_W-1:0]   x_max;
        logic [SAMPLE_W-1:0]   y_center;
        logic [SAMPLE_W-1:0]   y_min;
        logic [SAMPLE_W-1:0]   y_max;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic div_load;
        logic div_step;
        logic axis_store;
        logic axis_sel;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic x_valid;
        logic y_valid;
    } t_dp_sts;

endpackage

// ===== design/bdjn_intf.sv =====
// Channel interfaces for the button debounce and joystick normaliser.
// Depends on bdjn_pkg for the field widths.
interface bdjn_in_if import bdjn_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [TIME_W-1:0]   now_us;
    logic [LEVELS_W-1:0] button_levels;
    logic [SAMPLE_W-1:0] x_sample;
    logic                x_valid;
    logic [SAMPLE_W-1:0] y_sample;
    logic                y_valid;

    modport source (output valid, now_us, button_levels, x_sample, x_valid, y_sample, y_valid,
                    input ready);
    modport sink (input valid, now_us, button_levels, x_sample, x_valid, y_sample, y_valid,
                  output ready);
endinterface

interface bdjn_out_if import bdjn_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [LEVELS_W-1:0]      held_buttons;
    logic [LEVELS_W-1:0]      down_edges;
    logic [LEVELS_W-1:0]      up_edges;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;

    modport source (output valid, held_buttons, down_edges, up_edges, axis_x, axis_y,
                    input ready);
    modport sink (input valid, held_buttons, down_edges, up_edges, axis_x, axis_y,
                  output ready);
endinterface

// ===== design/bdjn_cfg.sv =====
// APB-style configuration register file.
// Depends on bdjn_pkg for the register indexes, reset values and t_cfg.
module bdjn_cfg import bdjn_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time <= RST_DEBOUNCE;
            r_cfg.deadzone      <= RST_DEADZONE;
            r_cfg.x_center      <= RST_CENTER;
            r_cfg.x_min         <= RST_MIN;
            r_cfg.x_max         <= RST_MAX;
            r_cfg.y_center      <= RST_CENTER;
            r_cfg.y_min         <= RST_MIN;
            r_cfg.y_max         <= RST_MAX;
        end else if (wr_en) begin
            case (idx)
                REG_DEBOUNCE: r_cfg.debounce_time <= pwdata[DEBOUNCE_W-1:0];
                REG_DEADZONE: r_cfg.deadzone      <= pwdata[DEADZONE_W-1:0];
                REG_X_CENTER: r_cfg.x_center      <= pwdata[SAMPLE_W-1:0];
                REG_X_MIN:    r_cfg.x_min         <= pwdata[SAMPLE_W-1:0];
                REG_X_MAX:    r_cfg.x_max         <= pwdata[SAMPLE_W-1:0];
                REG_Y_CENTER: r_cfg.y_center      <= pwdata[SAMPLE_W-1:0];
                REG_Y_MIN:    r_cfg.y_min         <= pwdata[SAMPLE_W-1:0];
                REG_Y_MAX:    r_cfg.y_max         <= pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            REG_DEBOUNCE: prdata = APB_DATA_W'(r_cfg.debounce_time);
            REG_DEADZONE: prdata = APB_DATA_W'(r_cfg.deadzone);
            REG_X_CENTER: prdata = APB_DATA_W'(r_cfg.x_center);
            REG_X_MIN:    prdata = APB_DATA_W'(r_cfg.x_min);
            REG_X_MAX:    prdata = APB_DATA_W'(r_cfg.x_max);
            REG_Y_CENTER: prdata = APB_DATA_W'(r_cfg.y_center);
            REG_Y_MIN:    prdata = APB_DATA_W'(r_cfg.y_min);
            REG_Y_MAX:    prdata = APB_DATA_W'(r_cfg.y_max);
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== design/bdjn_ctrl.sv =====
// Controller state machine: sequences debounce, the two axis divisions and the output load.
// Depends on bdjn_pkg for the command and status types and the divider length.
module bdjn_ctrl import bdjn_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_WRAP,
        ST_FINISH
    } t_state;

    t_state           r_state, n_state;
    logic             r_axis, n_axis;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             axis_valid;

    assign axis_valid  = r_axis ? i_sts.y_valid : i_sts.x_valid;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.axis_sel = r_axis;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_axis       = 1'b0;
                    n_state      = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (axis_valid) begin
                    o_cmd.div_load = 1'b1;
                    n_cnt          = '0;
                    n_state        = ST_DIV;
                end else if (!r_axis) begin
                    n_axis = 1'b1;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(DIV_CYCLES - 1)) begin
                    n_state = ST_WRAP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_WRAP: begin
                o_cmd.axis_store = 1'b1;
                if (!r_axis) begin
                    n_axis  = 1'b1;
                    n_state = ST_SETUP;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_axis      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== design/bdjn_dp.sv =====
// Datapath: debounce lanes, shared restoring divider, deadzone and clamp, output register.
// Depends on bdjn_pkg for widths, t_cfg and the command and status types.
module bdjn_dp import bdjn_pkg::*; #(
    parameter int NUM_BUTTONS = 8,
    parameter int ADC_BITS    = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    input  logic [TIME_W-1:0]        i_now_us,
    input  logic [LEVELS_W-1:0]      i_button_levels,
    input  logic [SAMPLE_W-1:0]      i_x_sample,
    input  logic                     i_x_valid,
    input  logic [SAMPLE_W-1:0]      i_y_sample,
    input  logic                     i_y_valid,
    output logic [LEVELS_W-1:0]      o_held_buttons,
    output logic [LEVELS_W-1:0]      o_down_edges,
    output logic [LEVELS_W-1:0]      o_up_edges,
    output logic signed [AXIS_W-1:0] o_axis_x,
    output logic signed [AXIS_W-1:0] o_axis_y
);

    localparam int MASK_BITS = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << MASK_BITS) - 64'd1);

    logic [NUM_BUTTONS-1:0] r_last_raw;
    logic [NUM_BUTTONS-1:0] r_stable_now;
    logic [NUM_BUTTONS-1:0] r_stable_before;
    logic [TIME_W-1:0]      r_stamp [NUM_BUTTONS];

    logic [SAMPLE_W-1:0] r_x_sample, r_y_sample;
    logic                r_x_valid, r_y_valid;

    logic [SAMPLE_W-1:0] r_div_den;
    logic [SAMPLE_W-1:0] r_div_rem;
    logic [DIV_W-1:0]    r_div_quo;
    logic                r_div_neg;
    logic                r_div_zero;

    logic signed [AXIS_W-1:0] r_held_x, r_held_y;

    logic [LEVELS_W-1:0]      r_out_held, r_out_down, r_out_up;
    logic signed [AXIS_W-1:0] r_out_x, r_out_y;

    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
        logic              raw;
        logic [TIME_W-1:0] age;

        if (b < LEVELS_W) begin : g_in
            assign raw = i_button_levels[b];
        end else begin : g_none
            assign raw = 1'b0;
        end

        assign age = i_now_us - r_stamp[b];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_last_raw[b]      <= 1'b0;
                r_stamp[b]         <= '0;
                r_stable_now[b]    <= 1'b0;
                r_stable_before[b] <= 1'b0;
            end else if (i_cmd.accept) begin
                if (raw != r_last_raw[b]) begin
                    r_last_raw[b] <= raw;
                    r_stamp[b]    <= i_now_us;
                end else if (age >= TIME_W'(i_cfg.debounce_time)) begin
                    r_stable_before[b] <= r_stable_now[b];
                    r_stable_now[b]    <= raw;
                end
            end
        end
    end

    logic [LEVELS_W-1:0] held_bits, down_bits, up_bits;

    for (genvar b = 0; b < LEVELS_W; b++) begin : g_outbit
        if (b < NUM_BUTTONS) begin : g_used
            assign held_bits[b] = r_stable_now[b];
            assign down_bits[b] = r_stable_now[b] && !r_stable_before[b];
            assign up_bits[b]   = !r_stable_now[b] && r_stable_before[b];
        end else begin : g_unused
            assign held_bits[b] = 1'b0;
            assign down_bits[b] = 1'b0;
            assign up_bits[b]   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x_sample <= i_x_sample & SAMPLE_MASK;
            r_y_sample <= i_y_sample & SAMPLE_MASK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
            r_y_valid <= 1'b0;
        end else if (i_cmd.accept) begin
            r_x_valid <= i_x_valid;
            r_y_valid <= i_y_valid;
        end
    end

    assign o_sts.x_valid = r_x_valid;
    assign o_sts.y_valid = r_y_valid;

    // Span and numerator magnitude for the selected axis.
    logic [SAMPLE_W-1:0] smp, ctr, lo, hi, mag_in;
    logic [SAMPLE_W:0]   span;
    logic                ge;

    assign smp    = i_cmd.axis_sel ? r_y_sample : r_x_sample;
    assign ctr    = i_cmd.axis_sel ? i_cfg.y_center : i_cfg.x_center;
    assign lo     = i_cmd.axis_sel ? i_cfg.y_min : i_cfg.x_min;
    assign hi     = i_cmd.axis_sel ? i_cfg.y_max : i_cfg.x_max;
    assign ge     = (smp >= ctr);
    assign span   = ge ? ({1'b0, hi} - {1'b0, ctr}) : ({1'b0, ctr} - {1'b0, lo});
    assign mag_in = ge ? (smp - ctr) : (ctr - smp);

    logic [SAMPLE_W-1:0] step_rem;
    logic [DIV_W-1:0]    step_quo;

    always_comb begin
        logic [SAMPLE_W:0] trial;
        step_rem = r_div_rem;
        step_quo = r_div_quo;
        for (int k = 0; k < DIV_PER_CYC; k++) begin
            trial    = {step_rem, step_quo[DIV_W-1]};
            step_quo = {step_quo[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div_den}) begin
                trial       = trial - {1'b0, r_div_den};
                step_quo[0] = 1'b1;
            end
            step_rem = trial[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_div_den  <= span[SAMPLE_W-1:0];
            r_div_rem  <= '0;
            r_div_quo  <= DIV_W'({mag_in, {Q_FRAC{1'b0}}});
            r_div_neg  <= !ge;
            r_div_zero <= span[SAMPLE_W] || (span == '0);
        end else if (i_cmd.div_step) begin
            r_div_rem <= step_rem;
            r_div_quo <= step_quo;
        end
    end

    // Deadzone, clamp and sign.
    logic [DIV_W-1:0]         quo;
    logic [MAG_W-1:0]         mag;
    logic signed [AXIS_W-1:0] scaled;

    assign quo    = r_div_zero ? '0 : r_div_quo;
    assign mag    = (quo > DIV_W'(Q_ONE)) ? MAG_W'(Q_ONE) : quo[MAG_W-1:0];
    assign scaled = (quo < DIV_W'(i_cfg.deadzone)) ? '0 :
                    (r_div_neg ? -AXIS_W'(mag) : AXIS_W'(mag));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_x <= '0;
            r_held_y <= '0;
        end else if (i_cmd.axis_store) begin
            if (i_cmd.axis_sel) begin
                r_held_y <= scaled;
            end else begin
                r_held_x <= scaled;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_held <= held_bits;
            r_out_down <= down_bits;
            r_out_up   <= up_bits;
            r_out_x    <= r_held_x;
            r_out_y    <= r_held_y;
        end
    end

    assign o_held_buttons = r_out_held;
    assign o_down_edges   = r_out_down;
    assign o_up_edges     = r_out_up;
    assign o_axis_x       = r_out_x;
    assign o_axis_y       = r_out_y;

endmodule

// ===== design/button_debounce_joystick_normalizer.sv =====
// Channel   Dir  Handshake        Payload
// i_in      in   valid / ready    now_us, button_levels, x_sample, x_valid, y_sample, y_valid
// o_out     out  valid / ready    held_buttons, down_edges, up_edges, axis_x, axis_y
// apb       in   psel / penable   paddr, pwdata, prdata (eight registers at 4-byte steps)
//
// A request passes through a debounce step, a setup step per axis, then per valid axis the
// shared divider at four quotient bits a cycle and a scaling step, then the output load.
// Reset is synchronous and active low; sample, divider and output registers are not reset.
// A new request is taken while a result waits in the output register; the load of the next
// result waits until that register is free.
// Top level of the button debounce and joystick normaliser; uses bdjn_pkg, the channel
// interfaces, bdjn_cfg, bdjn_ctrl and bdjn_dp.
module button_debounce_joystick_normalizer import bdjn_pkg::*; #(
    parameter int NUM_BUTTONS = 8,
    parameter int ADC_BITS    = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bdjn_in_if.sink               i_in,
    bdjn_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    bdjn_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bdjn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bdjn_dp #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .ADC_BITS    (ADC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_now_us        (i_in.now_us),
        .i_button_levels (i_in.button_levels),
        .i_x_sample      (i_in.x_sample),
        .i_x_valid       (i_in.x_valid),
        .i_y_sample      (i_in.y_sample),
        .i_y_valid       (i_in.y_valid),
        .o_held_buttons  (o_out.held_buttons),
        .o_down_edges    (o_out.down_edges),
        .o_up_edges      (o_out.up_edges),
        .o_axis_x        (o_out.axis_x),
        .o_axis_y        (o_out.axis_y)
    );

endmodule

// ===== design/bdjn_chk.sv =====
// Port-level checker for the button debounce and joystick normaliser, with its bind.
// Depends on bdjn_pkg for widths and the Q2.14 unit value.
module bdjn_chk import bdjn_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [LEVELS_W-1:0]      i_held,
    input logic [LEVELS_W-1:0]      i_down,
    input logic [LEVELS_W-1:0]      i_up,
    input logic signed [AXIS_W-1:0] i_axis_x,
    input logic signed [AXIS_W-1:0] i_axis_y
);

    localparam logic signed [AXIS_W-1:0] POS_ONE = AXIS_W'(Q_ONE);
    localparam logic signed [AXIS_W-1:0] NEG_ONE = -AXIS_W'(Q_ONE);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable({i_held, i_down, i_up,
                                                                i_axis_x, i_axis_y}))
        else $error("Result changed or vanished while stalled.");

    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("Result offered straight after reset.");

    a_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_down & ~i_held) == '0) && ((i_up & i_held) == '0))
        else $error("Edge bits disagree with the held buttons.");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_axis_x <= POS_ONE) && (i_axis_x >= NEG_ONE) &&
                        (i_axis_y <= POS_ONE) && (i_axis_y >= NEG_ONE))
        else $error("Axis value outside plus or minus one.");

endmodule

bind button_debounce_joystick_normalizer bdjn_chk u_bdjn_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_held      (o_out.held_buttons),
    .i_down      (o_out.down_edges),
    .i_up        (o_out.up_edges),
    .i_axis_x    (o_out.axis_x),
    .i_axis_y    (o_out.axis_y)
);

// ===== sim/tb_button_debounce_joystick_normalizer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the button debounce and joystick normaliser: a directed table,
// then random ticks in three idling regimes; results are checked by a local predictor or the table.
// Depends on bdjn_pkg, the channel interfaces and the top level button_debounce_joystick_normalizer.
module tb_button_debounce_joystick_normalizer;
    import bdjn_pkg::*;

    localparam int DRAIN_CYCLES   = 30;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TICKS_PER_SET  = 75;

    typedef struct packed {
        logic [TIME_W-1:0]   now_us;
        logic [LEVELS_W-1:0] levels;
        logic [SAMPLE_W-1:0] x_sample;
        logic                x_valid;
        logic [SAMPLE_W-1:0] y_sample;
        logic                y_valid;
    } t_tick;

    typedef struct packed {
        logic [LEVELS_W-1:0]      held;
        logic [LEVELS_W-1:0]      down;
        logic [LEVELS_W-1:0]      up;
        logic signed [AXIS_W-1:0] axis_x;
        logic signed [AXIS_W-1:0] axis_y;
    } t_tick_result;

    typedef struct {
        bit           is_cfg;
        t_reg_idx     reg_idx;
        logic [31:0]  value;
        t_tick        tick;
        bit           typed;
        t_tick_result res;
    } t_stim_row;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bdjn_in_if  tick_ch ();
    bdjn_out_if status_ch ();

    button_debounce_joystick_normalizer i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (tick_ch),
        .o_out   (status_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_cfg                     shadow_cfg;
    logic [LEVELS_W-1:0]      last_raw;
    logic [LEVELS_W-1:0]      stable_now;
    logic [LEVELS_W-1:0]      stable_before;
    logic [TIME_W-1:0]        change_stamp [LEVELS_W];
    logic signed [AXIS_W-1:0] held_x;
    logic signed [AXIS_W-1:0] held_y;

    t_tick_result pending_results [$];
    t_stim_row    directed_rows [$];
    int           mismatch_count;
    int           idle_cycles;
    int           in_idle_pct;
    int           out_idle_pct;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    function automatic logic signed [AXIS_W-1:0] scale_sample(input logic [SAMPLE_W-1:0] s,
            input logic [SAMPLE_W-1:0] centre, input logic [SAMPLE_W-1:0] lo,
            input logic [SAMPLE_W-1:0] hi);
        longint sv, cv, lv, hv, span, v, dz;
        sv = s;
        cv = centre;
        lv = lo;
        hv = hi;
        dz = shadow_cfg.deadzone;
        span = (sv >= cv) ? hv - cv : cv - lv;
        v = 0;
        if (span > 0) begin
            v = ((sv - cv) * Q_ONE) / span;
        end
        if (v > -dz && v < dz) begin
            return '0;
        end
        if (v > Q_ONE) begin
            v = Q_ONE;
        end
        if (v < -Q_ONE) begin
            v = -Q_ONE;
        end
        return v[AXIS_W-1:0];
    endfunction

    function automatic t_tick_result debounce_and_scale(input t_tick t);
        t_tick_result      r;
        logic [TIME_W-1:0] elapsed;
        int                b;
        for (b = 0; b < LEVELS_W; b++) begin
            elapsed = t.now_us - change_stamp[b];
            if (t.levels[b] != last_raw[b]) begin
                last_raw[b] = t.levels[b];
                change_stamp[b] = t.now_us;
            end else if (elapsed >= TIME_W'(shadow_cfg.debounce_time)) begin
                stable_before[b] = stable_now[b];
                stable_now[b] = t.levels[b];
            end
        end
        if (t.x_valid) begin
            held_x = scale_sample(t.x_sample, shadow_cfg.x_center, shadow_cfg.x_min,
                                  shadow_cfg.x_max);
        end
        if (t.y_valid) begin
            held_y = scale_sample(t.y_sample, shadow_cfg.y_center, shadow_cfg.y_min,
                                  shadow_cfg.y_max);
        end
        r.held = stable_now;
        r.down = stable_now & ~stable_before;
        r.up = ~stable_now & stable_before;
        r.axis_x = held_x;
        r.axis_y = held_y;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input t_reg_idx idx, input logic [31:0] value);
        t_stim_row r;
        r = '{reg_idx: REG_DEBOUNCE, default: '0};
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.value = value;
        return r;
    endfunction

    function automatic t_stim_row tick_row(input logic [31:0] now, input logic [7:0] lv,
            input logic [11:0] xs, input logic xv, input logic [11:0] ys, input logic yv);
        t_stim_row r;
        r = '{reg_idx: REG_DEBOUNCE, default: '0};
        r.tick = '{now_us: now, levels: lv, x_sample: xs, x_valid: xv, y_sample: ys,
                   y_valid: yv};
        return r;
    endfunction

    function automatic t_stim_row checked_row(input logic [31:0] now, input logic [7:0] lv,
            input logic [11:0] xs, input logic xv, input logic [11:0] ys, input logic yv,
            input logic [7:0] held, input logic [7:0] down, input logic [7:0] up,
            input int ax, input int ay);
        t_stim_row r;
        r = tick_row(now, lv, xs, xv, ys, yv);
        r.typed = 1'b1;
        r.res = '{held: held, down: down, up: up, axis_x: AXIS_W'(ax), axis_y: AXIS_W'(ay)};
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] centre);
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2, 3: return SAMPLE_W'(centre + $urandom_range(400) - 200);
            default: return SAMPLE_W'($urandom_range(4095));
        endcase
    endfunction

    task automatic push_tick(input t_tick t, input bit use_typed,
                             input t_tick_result typed_res);
        t_tick_result predicted;
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct) begin
            tick_ch.valid <= 1'b0;
            @(negedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.now_us <= t.now_us;
        tick_ch.button_levels <= t.levels;
        tick_ch.x_sample <= t.x_sample;
        tick_ch.x_valid <= t.x_valid;
        tick_ch.y_sample <= t.y_sample;
        tick_ch.y_valid <= t.y_valid;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
        predicted = debounce_and_scale(t);
        pending_results.push_back(use_typed ? typed_res : predicted);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Each write is followed by a read-back; psel stays high across the two transfers.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] stored;
        case (idx)
            REG_DEBOUNCE: shadow_cfg.debounce_time = value[DEBOUNCE_W-1:0];
            REG_DEADZONE: shadow_cfg.deadzone = value[DEADZONE_W-1:0];
            REG_X_CENTER: shadow_cfg.x_center = value[SAMPLE_W-1:0];
            REG_X_MIN:    shadow_cfg.x_min = value[SAMPLE_W-1:0];
            REG_X_MAX:    shadow_cfg.x_max = value[SAMPLE_W-1:0];
            REG_Y_CENTER: shadow_cfg.y_center = value[SAMPLE_W-1:0];
            REG_Y_MIN:    shadow_cfg.y_min = value[SAMPLE_W-1:0];
            default:      shadow_cfg.y_max = value[SAMPLE_W-1:0];
        endcase
        case (idx)
            REG_DEBOUNCE: stored = 32'(value[DEBOUNCE_W-1:0]);
            REG_DEADZONE: stored = 32'(value[DEADZONE_W-1:0]);
            default:      stored = 32'(value[SAMPLE_W-1:0]);
        endcase
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field($sformatf("read-back of register %s", idx.name()), prdata, stored);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic randomise_settings();
        logic [SAMPLE_W-1:0] centre;
        int                  a;
        case ($urandom_range(5))
            0: write_reg(REG_DEBOUNCE, 32'd0);
            1: write_reg(REG_DEBOUNCE, 32'hFF_FFFF);
            default: write_reg(REG_DEBOUNCE, $urandom_range(3000));
        endcase
        case ($urandom_range(6))
            0: write_reg(REG_DEADZONE, 32'd0);
            1: write_reg(REG_DEADZONE, Q_ONE);
            2: write_reg(REG_DEADZONE, 32'h7FFF);
            default: write_reg(REG_DEADZONE, $urandom_range(4000));
        endcase
        for (a = 0; a < 2; a++) begin
            case ($urandom_range(4))
                0: centre = '0;
                1: centre = '1;
                default: centre = SAMPLE_W'($urandom_range(3000, 1000));
            endcase
            write_reg(a == 0 ? REG_X_CENTER : REG_Y_CENTER, centre);
            write_reg(a == 0 ? REG_X_MIN : REG_Y_MIN,
                      ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(600));
            write_reg(a == 0 ? REG_X_MAX : REG_Y_MAX,
                      ($urandom_range(3) == 0) ? $urandom_range(4095)
                                               : $urandom_range(4095, 3500));
        end
    endtask

    always @(negedge clk) begin
        status_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge clk) begin : result_check
        t_tick_result want;
        if (rst_n && status_ch.valid && status_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result arrived with no request outstanding");
            end else begin
                want = pending_results.pop_front();
                check_field("held_buttons", status_ch.held_buttons, want.held);
                check_field("down_edges", status_ch.down_edges, want.down);
                check_field("up_edges", status_ch.up_edges, want.up);
                check_field("axis_x", status_ch.axis_x, want.axis_x);
                check_field("axis_y", status_ch.axis_y, want.axis_y);
            end
        end
    end

    always @(posedge clk) begin
        if ((tick_ch.valid && tick_ch.ready) || (status_ch.valid && status_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_tick       t;
        logic [31:0] clock_us;
        logic [7:0]  levels;
        int          regime;
        int          set_no;
        int          n;
        int          b;

        rst_n <= 1'b0;
        tick_ch.valid <= 1'b0;
        tick_ch.now_us <= '0;
        tick_ch.button_levels <= '0;
        tick_ch.x_sample <= '0;
        tick_ch.x_valid <= 1'b0;
        tick_ch.y_sample <= '0;
        tick_ch.y_valid <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        idle_cycles = 0;
        mismatch_count = 0;
        shadow_cfg = '{RST_DEBOUNCE, RST_DEADZONE, RST_CENTER, RST_MIN, RST_MAX,
                       RST_CENTER, RST_MIN, RST_MAX};
        last_raw = '0;
        stable_now = '0;
        stable_before = '0;
        for (b = 0; b < LEVELS_W; b++) begin
            change_stamp[b] = '0;
        end
        held_x = '0;
        held_y = '0;
        in_idle_pct = 37;
        out_idle_pct = 47;

        directed_rows.push_back(checked_row(0, 8'h00, 2048, 1, 2048, 1, 8'h00, 8'h00, 8'h00,
                                            0, 0));
        directed_rows.push_back(checked_row(100, 8'hFF, 4095, 1, 0, 1, 8'h00, 8'h00, 8'h00,
                                            Q_ONE, -Q_ONE));
        directed_rows.push_back(checked_row(20100, 8'hFF, 0, 0, 0, 0, 8'hFF, 8'hFF, 8'h00,
                                            Q_ONE, -Q_ONE));
        directed_rows.push_back(checked_row(20101, 8'hFF, 0, 0, 0, 0, 8'hFF, 8'h00, 8'h00,
                                            Q_ONE, -Q_ONE));
        directed_rows.push_back(checked_row(20200, 8'h00, 0, 1, 4095, 1, 8'hFF, 8'h00, 8'h00,
                                            -Q_ONE, Q_ONE));
        directed_rows.push_back(checked_row(40200, 8'h00, 0, 0, 0, 0, 8'h00, 8'h00, 8'hFF,
                                            -Q_ONE, Q_ONE));
        directed_rows.push_back(tick_row(32'hFFFF_FF00, 8'hA5, 2252, 1, 1843, 1));
        directed_rows.push_back(tick_row(32'h0000_4E00, 8'hA5, 2253, 1, 2049, 0));
        directed_rows.push_back(tick_row(32'h0000_4E01, 8'h5A, 1844, 1, 1844, 1));
        directed_rows.push_back(cfg_row(REG_DEBOUNCE, 32'd0));
        directed_rows.push_back(tick_row(32'h0000_4E01, 8'h5A, 1024, 1, 3072, 1));
        directed_rows.push_back(tick_row(32'h0000_4E01, 8'h5A, 0, 0, 0, 0));
        directed_rows.push_back(cfg_row(REG_DEBOUNCE, 32'hFF_FFFF));
        directed_rows.push_back(tick_row(32'h0000_4E02, 8'h0F, 2047, 1, 2047, 1));
        directed_rows.push_back(tick_row(32'h0100_4E00, 8'h0F, 2048, 1, 2048, 0));
        directed_rows.push_back(tick_row(32'h0100_4E01, 8'h0F, 2049, 0, 2048, 1));
        directed_rows.push_back(cfg_row(REG_X_MIN, 32'd2048));
        directed_rows.push_back(cfg_row(REG_X_MAX, 32'd2048));
        directed_rows.push_back(cfg_row(REG_Y_CENTER, 32'd0));
        directed_rows.push_back(cfg_row(REG_Y_MIN, 32'd4095));
        directed_rows.push_back(cfg_row(REG_Y_MAX, 32'd0));
        directed_rows.push_back(cfg_row(REG_DEADZONE, 32'd0));
        directed_rows.push_back(tick_row(32'h0100_4E02, 8'h0F, 4095, 1, 4095, 1));
        directed_rows.push_back(tick_row(32'h0100_4E03, 8'h0F, 0, 1, 0, 1));
        directed_rows.push_back(cfg_row(REG_X_CENTER, 32'd4095));
        directed_rows.push_back(cfg_row(REG_X_MIN, 32'd0));
        directed_rows.push_back(cfg_row(REG_X_MAX, 32'd4095));
        directed_rows.push_back(tick_row(32'h0100_4E04, 8'hF0, 4095, 1, 0, 1));
        directed_rows.push_back(tick_row(32'h0100_4E05, 8'hF0, 0, 1, 4095, 1));
        directed_rows.push_back(cfg_row(REG_DEADZONE, 32'h7FFF));
        directed_rows.push_back(cfg_row(REG_Y_CENTER, 32'd2048));
        directed_rows.push_back(cfg_row(REG_Y_MIN, 32'd0));
        directed_rows.push_back(cfg_row(REG_Y_MAX, 32'd4095));
        directed_rows.push_back(tick_row(32'h0100_4E06, 8'hF0, 0, 1, 4095, 1));
        directed_rows.push_back(cfg_row(REG_DEADZONE, Q_ONE));
        directed_rows.push_back(tick_row(32'h0100_4E07, 8'hF0, 0, 1, 4095, 1));
        directed_rows.push_back(tick_row(32'h0100_4E08, 8'hF0, 2048, 1, 3000, 1));
        directed_rows.push_back(cfg_row(REG_DEBOUNCE, 32'(RST_DEBOUNCE)));

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                wait_idle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            end else begin
                push_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].res);
            end
        end

        clock_us = 32'h0100_4E08;
        levels = 8'hF0;
        for (regime = 0; regime < 3; regime++) begin
            in_idle_pct = (regime == 0) ? 37 : (regime == 1) ? 47 : 0;
            out_idle_pct = (regime == 0) ? 47 : (regime == 1) ? 37 : 0;
            for (set_no = 0; set_no < 2; set_no++) begin
                wait_idle();
                randomise_settings();
                for (n = 0; n < TICKS_PER_SET; n++) begin
                    case ($urandom_range(15))
                        0: clock_us += $urandom();
                        1, 2: clock_us += 0;
                        default: clock_us +=
                            $urandom_range(int'(shadow_cfg.debounce_time) / 3 + 50);
                    endcase
                    case ($urandom_range(9))
                        0: levels = 8'($urandom());
                        1, 2: levels[$urandom_range(LEVELS_W - 1)] ^= 1'b1;
                        default: levels = levels;
                    endcase
                    t.now_us = clock_us;
                    t.levels = levels;
                    t.x_valid = ($urandom_range(3) != 0);
                    t.x_sample = pick_sample(shadow_cfg.x_center);
                    t.y_valid = ($urandom_range(3) != 0);
                    t.y_sample = pick_sample(shadow_cfg.y_center);
                    push_tick(t, 1'b0, '0);
                end
            end
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
